// ----- hdl/orma_pkg.sv -----
package orma_pkg;

  localparam int WindowDepthDefault = 16;

  localparam logic [4:0]  WindowLenReset = 5'd10;
  localparam logic [15:0] NormGainReset  = 16'd256;
  localparam logic [15:0] MinTempReset   = 16'hFCE0;  // -800
  localparam logic [15:0] MaxTempReset   = 16'd2400;
  localparam int          OutlierMinCount = 3;

  typedef enum logic [1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_NORM_GAIN  = 2'd1,
    CFG_MIN_TEMP   = 2'd2,
    CFG_MAX_TEMP   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_AVERAGED   = 2'd0,
    OUT_OUT_RANGE  = 2'd1,
    OUT_OUTLIER    = 2'd2
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_STAT,
    ST_TEST,
    ST_DECIDE,
    ST_EVICT_RD,
    ST_EVICT,
    ST_INSERT,
    ST_DIV,
    ST_SCALE,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic stat;
    logic test;
    logic evict_rd;
    logic evict;
    logic insert;
    logic div_start;
    logic div_step;
    logic scale_mean;
    logic scale_held;
    logic clamp;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic outlier;
    logic need_evict;
    logic div_done;
  } dp_sts_t;

endpackage

// ----- hdl/orma_stream_if.sv -----
interface orma_stream_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/orma_ctrl.sv -----
module orma_ctrl
  import orma_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_xfer,
  input  logic    out_busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    idle
);

  state_t state_r, state_nxt;
  logic   outl_r, outl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outl_r  <= outl_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    outl_nxt  = outl_r;
    case (state_r)
      ST_IDLE:     if (in_xfer) state_nxt = ST_RANGE;
      ST_RANGE:    state_nxt = sts.in_range ? ST_STAT : ST_OUT;
      ST_STAT:     state_nxt = ST_TEST;
      ST_TEST:     state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        outl_nxt = sts.outlier;
        if (sts.outlier)         state_nxt = ST_SCALE;
        else if (sts.need_evict) state_nxt = ST_EVICT_RD;
        else                     state_nxt = ST_INSERT;
      end
      ST_EVICT_RD: state_nxt = ST_EVICT;
      ST_EVICT:    state_nxt = ST_INSERT;
      ST_INSERT:   state_nxt = ST_DIV;
      ST_DIV:      if (sts.div_done) state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_OUT;
      ST_OUT:      if (!out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      ST_IDLE:     begin idle = 1'b1; cmd.load = in_xfer; end
      ST_STAT:     cmd.stat = 1'b1;
      ST_TEST:     cmd.test = 1'b1;
      ST_EVICT_RD: cmd.evict_rd = 1'b1;
      ST_EVICT:    cmd.evict = 1'b1;
      ST_INSERT:   begin cmd.insert = 1'b1; cmd.div_start = 1'b1; end
      ST_DIV:      cmd.div_step = 1'b1;
      ST_SCALE:    begin cmd.scale_mean = !outl_r; cmd.scale_held = outl_r; end
      ST_CLAMP:    cmd.clamp = 1'b1;
      ST_OUT:      cmd.out_load = !out_busy;
      default:     ;
    endcase
  end

endmodule

// ----- hdl/orma_datapath.sv -----
module orma_datapath
  import orma_pkg::*;
#(
  parameter int WINDOW_DEPTH = WindowDepthDefault
)(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic signed [15:0] sample,
  input  logic [4:0]         window_len,
  input  logic [15:0]        norm_gain,
  input  logic signed [15:0] min_temp,
  input  logic signed [15:0] max_temp,
  output dp_sts_t            sts,
  output logic signed [15:0] res_value,
  output logic [1:0]         res_outcome
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 16 + CW + 1;
  localparam int QW = 32 + CW;
  localparam int DW = SW + CW + 1;
  localparam int DCW = $clog2(SW + 2);

  logic signed [15:0] ring [WINDOW_DEPTH];
  logic signed [15:0] rd_r;
  logic signed [15:0] x_r;
  logic [CW-1:0]      cnt_r;
  logic [PW-1:0]      wp_r;
  logic signed [SW-1:0] sum_r;
  logic [QW-1:0]      sq_r;
  logic signed [15:0] held_r;

  // statistics
  logic signed [DW-1:0]   d_r;
  logic signed [2*QW:0]   nq_r, ss_r;
  logic signed [2*DW-1:0] d_sq;
  logic                   outl_r;
  logic signed [31:0]     x_sq, rd_sq;
  logic                   in_range;

  // divider
  logic [SW-1:0]  quo_r, rem_r;
  logic           neg_r;
  logic [DCW-1:0] dbit_r;
  logic [CW-1:0]  wl_eff;
  logic [SW-1:0]  sum_mag;
  logic [SW:0]    trial;

  logic signed [33:0] prod_r;
  logic signed [25:0] shifted;

  logic [CW:0]   oldest_w;
  logic [PW-1:0] oldest;

  always_comb begin
    if (window_len == '0) wl_eff = CW'(1);
    else if (int'(window_len) > WINDOW_DEPTH) wl_eff = CW'(WINDOW_DEPTH);
    else wl_eff = CW'(window_len);
  end

  assign in_range       = !((x_r < min_temp) || (x_r > max_temp));
  assign sts.in_range   = in_range;
  assign sts.outlier    = outl_r;
  assign sts.need_evict = (cnt_r >= wl_eff) && (cnt_r != '0);
  assign sts.div_done   = (dbit_r == DCW'(1));

  assign x_sq    = x_r * x_r;
  assign rd_sq   = rd_r * rd_r;
  assign d_sq    = d_r * d_r;
  assign sum_mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign trial   = {rem_r, quo_r[SW-1]} - {(SW+1-CW)'(0), cnt_r};
  assign shifted = 26'(prod_r >>> 8);

  // ring position of the oldest stored sample
  assign oldest_w = (CW+1)'(wp_r) + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(cnt_r);
  assign oldest   = (oldest_w >= (CW+1)'(WINDOW_DEPTH)) ?
                    PW'(oldest_w - (CW+1)'(WINDOW_DEPTH)) : PW'(oldest_w);

  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= sample;
    if (cmd.evict_rd) rd_r <= ring[oldest];
    if (cmd.insert) ring[wp_r] <= x_r;
    if (cmd.stat) begin
      d_r  <= $signed({1'b0, cnt_r}) * x_r - sum_r;
      nq_r <= $signed({1'b0, cnt_r}) * $signed({1'b0, sq_r});
      ss_r <= sum_r * sum_r;
    end
    if (cmd.scale_mean)
      prod_r <= (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}))
                * $signed({1'b0, norm_gain});
    if (cmd.scale_held)
      prod_r <= held_r * $signed({1'b0, norm_gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wp_r   <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
      held_r <= '0;
      outl_r <= 1'b0;
      dbit_r <= '0;
      res_value   <= '0;
      res_outcome <= OUT_AVERAGED;
    end else begin
      if (cmd.test)
        outl_r <= (cnt_r >= CW'(OutlierMinCount)) && (d_sq > 4 * (nq_r - ss_r));
      if (cmd.evict) begin
        sum_r <= sum_r - rd_r;
        sq_r  <= sq_r - QW'($unsigned(rd_sq));
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.insert) begin
        wp_r  <= (wp_r == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + x_r;
        sq_r  <= sq_r + QW'($unsigned(x_sq));
      end
      if (cmd.div_start) dbit_r <= DCW'(SW + 1);
      if (cmd.div_step && dbit_r != '0) dbit_r <= dbit_r - 1'b1;
      if (cmd.clamp) begin
        if (shifted < min_temp)      held_r <= min_temp;
        else if (shifted > max_temp) held_r <= max_temp;
        else                         held_r <= 16'(shifted);
      end
      if (cmd.out_load) begin
        res_value   <= held_r;
        res_outcome <= !in_range ? OUT_OUT_RANGE : (outl_r ? OUT_OUTLIER : OUT_AVERAGED);
      end
    end
  end

  // serial restoring divide of |S| by n: one load step, then one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      if (dbit_r == DCW'(SW + 1)) begin
        neg_r <= sum_r[SW-1];
        quo_r <= sum_mag;
        rem_r <= '0;
      end else if (dbit_r != '0) begin
        if (!trial[SW]) begin
          rem_r <= trial[SW-1:0];
          quo_r <= {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SW-2:0], quo_r[SW-1]};
          quo_r <= {quo_r[SW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- hdl/outlier_rejecting_moving_average_unit.sv -----
// One result per sample, taken from in_ and delivered on out_. One sample is in
// flight at a time and in_ready is high only while the block is idle. A sample
// out of range goes from the range check to the load of the output register; an
// outlier takes range check, variance test, gain multiply, clamp and output load;
// an averaged sample takes range check, variance test, the optional eviction of
// the oldest sample, the ring write, a bit-serial restoring divide of the window
// sum by the count with a load step first, then gain multiply, clamp and output
// register load. A result not yet taken holds the block in that last step.
module outlier_rejecting_moving_average_unit
  import orma_pkg::*;
#(
  parameter int WINDOW_DEPTH = WindowDepthDefault
)(
  input  logic           clk,
  input  logic           rst_n,
  orma_stream_if.sink    in_if,
  orma_stream_if.source  out_if,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);

  logic [4:0]         window_len_r;
  logic [15:0]        norm_gain_r;
  logic signed [15:0] min_temp_r, max_temp_r;
  logic               out_valid_r;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic               idle;
  logic signed [15:0] res_value;
  logic [1:0]         res_outcome;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WindowLenReset;
      norm_gain_r  <= NormGainReset;
      min_temp_r   <= MinTempReset;
      max_temp_r   <= MaxTempReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEN: window_len_r <= cfg_wdata[4:0];
        CFG_NORM_GAIN:  norm_gain_r  <= cfg_wdata;
        CFG_MIN_TEMP:   min_temp_r   <= cfg_wdata;
        CFG_MAX_TEMP:   max_temp_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  assign in_if.ready   = idle;
  assign out_if.valid  = out_valid_r;
  assign out_if.data   = {res_outcome, res_value};

  orma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_xfer  (in_if.valid && in_if.ready),
    .out_busy (out_valid_r && !out_if.ready),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  orma_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample      (in_if.data[15:0]),
    .window_len  (window_len_r),
    .norm_gain   (norm_gain_r),
    .min_temp    (min_temp_r),
    .max_temp    (max_temp_r),
    .sts         (sts),
    .res_value   (res_value),
    .res_outcome (res_outcome)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |-> idle) else $error("accept while busy");
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.data[17:16] != 2'd3) else $error("bad outcome");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
`endif

endmodule
